// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/i2cts_pkg.sv -----
// Package for the I2C target stream bridge: actions, register map, control codes,
// ring pointer helpers and the CRC-32 byte step. No dependencies.
`default_nettype none

package i2cts_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SLOT_W     = 4;
    localparam int ACT_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int M_DATA_W   = 16;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_START = 3'd0,
        ACT_WR_BYTE  = 3'd1,
        ACT_RD_DONE  = 3'd2,
        ACT_RD_REQ   = 3'd3,
        ACT_STOP     = 3'd4,
        ACT_PUSH     = 3'd5,
        ACT_POP      = 3'd6
    } action_t;

    localparam logic [3:0] REG_DATA  = 4'h0;
    localparam logic [3:0] REG_COUNT = 4'h1;
    localparam logic [3:0] REG_OCRC0 = 4'h2;
    localparam logic [3:0] REG_OCRC3 = 4'h5;
    localparam logic [3:0] REG_ICRC0 = 4'h6;
    localparam logic [3:0] REG_ICRC3 = 4'h9;
    localparam logic [3:0] REG_CTRL  = 4'hA;

    localparam logic [7:0] CTRL_OUT_COMMIT = 8'h80;
    localparam logic [7:0] CTRL_OUT_REWIND = 8'h20;
    localparam logic [7:0] CTRL_IN_COMMIT  = 8'h40;
    localparam logic [7:0] CTRL_IN_REWIND  = 8'h10;

    localparam logic [7:0]  BYTE_FOREIGN = 8'hFF;
    localparam logic [7:0]  COUNT_MAX    = 8'hFF;
    localparam logic [31:0] CRC_PRESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

    function automatic ptr_t ring_next(input ptr_t p);
        return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ring_count(input ptr_t h, input ptr_t t);
        logic [PTR_W:0] diff;
        diff = {1'b0, h} - {1'b0, t};
        if (h < t) begin
            diff = diff + (PTR_W+1)'(RING_DEPTH);
        end
        return diff[PTR_W-1:0];
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/i2cts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module i2cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/i2c_target_stream_fifo_crc.sv -----
// Top level of the I2C target stream bridge with two byte rings and running CRC-32.
// Depends on i2cts_pkg and i2cts_ram.
//
// Usage:
//   s_ channel: one transfer per event; s_tuser carries the action (bus write
//   start, write byte, read done, read request, stop, local push, local pop),
//   s_tdata the byte. m_ channel: one result transfer per event, in order.
//   cfg_wr_en/cfg_wr_data set the stream slot nibble; write it only when idle.
//   Each event passes through the input register, then the result register.
//   Throughput: one event per cycle while the receiver does not stall; each
//   event is handled between the input register and the result register,
//   with the ring RAMs read ahead at the next tail address (write bypass included).
//   Reset (synchronous, aresetn low) empties both rings, presets both CRCs,
//   clears the slot, control and selected register; no clearing pass.
//   If the receiver stalls, the result register holds, one more event waits
//   in the input register, then s_tready drops.
`default_nettype none

module i2c_target_stream_fifo_crc (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [i2cts_pkg::SLOT_W-1:0]     cfg_wr_data,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [i2cts_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] data
    input  wire logic [i2cts_pkg::ACT_W-1:0]      s_tuser,  // [2:0] action
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [i2cts_pkg::M_DATA_W-1:0]   m_tdata   // [7:0] read_byte, [8] nack,
                                                            // [9] accepted, [10] dropped,
                                                            // [15:11] zero
);

    import i2cts_pkg::*;

    logic               in_valid_reg;
    action_t            act_reg;
    logic [7:0]         data_reg;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [SLOT_W-1:0]  slot_reg;
    logic               pfb_reg, pfb_next;
    logic [7:0]         sel_reg, sel_next;
    logic [7:0]         ctrl_reg, ctrl_next;
    ptr_t               in_head_reg, in_head_next;
    ptr_t               in_tail_reg, in_tail_next;
    ptr_t               in_mark_reg, in_mark_next;
    logic [31:0]        in_crc_reg, in_crc_next;
    ptr_t               out_head_reg, out_head_next;
    ptr_t               out_tail_reg, out_tail_next;
    ptr_t               out_mark_reg, out_mark_next;
    logic [31:0]        out_crc_reg, out_crc_next;
    logic [RING_DEPTH-1:0] out_filled_reg;

    logic               in_we, out_we;
    logic [7:0]         in_q, out_q;
    logic               in_byp_reg, out_byp_reg;
    logic [7:0]         in_byp_data_reg, out_byp_data_reg;
    logic               out_rvalid_reg;

    logic               s_accept, fire;
    logic [7:0]         sel_eff;
    logic               ours;
    logic [3:0]         fn;
    ptr_t               out_cnt;
    logic [7:0]         out_rd, in_rd;
    logic [31:0]        out_crc_inv, in_crc_inv;
    logic [1:0]         crc_idx;
    logic [7:0]         rb;
    logic               nack, acc, drop;

    assign s_accept = s_tvalid && s_tready;
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign out_rd = out_rvalid_reg ? (out_byp_reg ? out_byp_data_reg : out_q) : 8'h00;
    assign in_rd  = in_byp_reg ? in_byp_data_reg : in_q;

    always_comb begin
        pfb_next      = pfb_reg;
        sel_next      = sel_reg;
        ctrl_next     = ctrl_reg;
        in_head_next  = in_head_reg;
        in_tail_next  = in_tail_reg;
        in_mark_next  = in_mark_reg;
        in_crc_next   = in_crc_reg;
        out_head_next = out_head_reg;
        out_tail_next = out_tail_reg;
        out_mark_next = out_mark_reg;
        out_crc_next  = out_crc_reg;
        in_we         = 1'b0;
        out_we        = 1'b0;
        rb            = 8'h00;
        nack          = 1'b0;
        acc           = 1'b0;
        drop          = 1'b0;

        sel_eff     = (act_reg == ACT_WR_BYTE && !pfb_reg) ? data_reg : sel_reg;
        ours        = (sel_eff[7:4] == slot_reg);
        fn          = sel_eff[3:0];
        out_cnt     = ring_count(out_head_reg, out_tail_reg);
        out_crc_inv = ~out_crc_reg;
        in_crc_inv  = ~in_crc_reg;
        crc_idx     = 2'(fn - REG_OCRC0);

        if (fire) begin
            case (act_reg)
                ACT_WR_START, ACT_STOP: begin
                    pfb_next = 1'b0;
                end
                ACT_WR_BYTE: begin
                    sel_next = sel_eff;
                    pfb_next = 1'b1;
                    if (!ours) begin
                        nack = 1'b1;
                    end else if (pfb_reg) begin
                        if (fn == REG_DATA) begin
                            if (ring_next(in_head_reg) != in_tail_reg) begin
                                in_we        = 1'b1;
                                in_crc_next  = crc32_byte(in_crc_reg, data_reg);
                                in_head_next = ring_next(in_head_reg);
                            end else begin
                                drop = 1'b1;
                            end
                        end else if (fn == REG_CTRL) begin
                            ctrl_next = data_reg;
                            case (data_reg)
                                CTRL_OUT_COMMIT: begin
                                    out_crc_next  = CRC_PRESET;
                                    out_mark_next = out_tail_reg;
                                end
                                CTRL_OUT_REWIND: begin
                                    out_crc_next  = CRC_PRESET;
                                    out_tail_next = out_mark_reg;
                                end
                                CTRL_IN_COMMIT: begin
                                    in_crc_next  = CRC_PRESET;
                                    in_mark_next = in_head_reg;
                                end
                                CTRL_IN_REWIND: begin
                                    in_crc_next  = CRC_PRESET;
                                    in_head_next = in_mark_reg;
                                end
                                default: begin
                                end
                            endcase
                        end else begin
                            nack = 1'b1;
                        end
                    end
                end
                ACT_RD_DONE: begin
                    pfb_next = 1'b1;
                    if (fn != REG_DATA) begin
                        rb = 8'h00;
                    end else if (!ours) begin
                        rb = BYTE_FOREIGN;
                    end else begin
                        rb = out_rd;
                        if (out_cnt != '0) begin
                            out_crc_next  = crc32_byte(out_crc_reg, out_rd);
                            out_tail_next = ring_next(out_tail_reg);
                        end
                    end
                end
                ACT_RD_REQ: begin
                    if (!ours) begin
                        rb = BYTE_FOREIGN;
                    end else begin
                        case (fn) inside
                            REG_COUNT: begin
                                if (pfb_reg) begin
                                    rb = 8'h00;
                                end else if (out_cnt > ptr_t'(COUNT_MAX)) begin
                                    rb = COUNT_MAX;
                                end else begin
                                    rb = 8'(out_cnt);
                                end
                            end
                            REG_DATA: begin
                                rb = (out_cnt != '0) ? out_rd : 8'h00;
                            end
                            [REG_OCRC0:REG_OCRC3]: begin
                                rb = out_crc_inv[crc_idx*8 +: 8];
                            end
                            [REG_ICRC0:REG_ICRC3]: begin
                                rb = in_crc_inv[2'(fn - REG_ICRC0)*8 +: 8];
                            end
                            REG_CTRL: begin
                                rb = ctrl_reg;
                            end
                            default: begin
                                rb = 8'h00;
                            end
                        endcase
                    end
                end
                ACT_PUSH: begin
                    if (ring_next(out_head_reg) != out_mark_reg) begin
                        out_we        = 1'b1;
                        out_head_next = ring_next(out_head_reg);
                        acc           = 1'b1;
                    end
                end
                ACT_POP: begin
                    if (in_mark_reg != in_tail_reg) begin
                        rb           = in_rd;
                        in_tail_next = ring_next(in_tail_reg);
                        acc          = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    i2cts_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_in_ram (
        .aclk  (aclk),
        .we    (in_we),
        .waddr (in_head_reg),
        .wdata (data_reg),
        .raddr (in_tail_next),
        .rdata (in_q)
    );

    i2cts_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_out_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (out_head_reg),
        .wdata (data_reg),
        .raddr (out_tail_next),
        .rdata (out_q)
    );

    // payload and bypass registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= action_t'(s_tuser);
            data_reg <= s_tdata;
        end
        if (fire) begin
            m_data_reg <= {5'b0, drop, acc, nack, rb};
        end
        in_byp_reg       <= in_we && (in_head_reg == in_tail_next);
        in_byp_data_reg  <= data_reg;
        out_byp_reg      <= out_we && (out_head_reg == out_tail_next);
        out_byp_data_reg <= data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            slot_reg       <= '0;
            pfb_reg        <= 1'b0;
            sel_reg        <= 8'h00;
            ctrl_reg       <= 8'h00;
            in_head_reg    <= '0;
            in_tail_reg    <= '0;
            in_mark_reg    <= '0;
            in_crc_reg     <= CRC_PRESET;
            out_head_reg   <= '0;
            out_tail_reg   <= '0;
            out_mark_reg   <= '0;
            out_crc_reg    <= CRC_PRESET;
            out_filled_reg <= '0;
            out_rvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                slot_reg <= cfg_wr_data;
            end
            pfb_reg      <= pfb_next;
            sel_reg      <= sel_next;
            ctrl_reg     <= ctrl_next;
            in_head_reg  <= in_head_next;
            in_tail_reg  <= in_tail_next;
            in_mark_reg  <= in_mark_next;
            in_crc_reg   <= in_crc_next;
            out_head_reg <= out_head_next;
            out_tail_reg <= out_tail_next;
            out_mark_reg <= out_mark_next;
            out_crc_reg  <= out_crc_next;
            if (out_we) begin
                out_filled_reg[out_head_reg] <= 1'b1;
            end
            out_rvalid_reg <= (out_we && (out_head_reg == out_tail_next))
                              || out_filled_reg[out_tail_next];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/i2cts_checker.sv -----
// Port-level assertions for i2c_target_stream_fifo_crc, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")
    `ASSERT_CLK(a_latency, aclk, aresetn, s_tvalid && s_tready |-> ##2 m_tvalid,
        "no result two cycles after a transfer")
    `ASSERT_CLK(a_nack_alone, aclk, aresetn,
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'h00 && !m_tdata[9] && !m_tdata[10],
        "nack with other fields set")
    `ASSERT_CLK(a_drop_alone, aclk, aresetn,
        m_tvalid && m_tdata[10] |-> m_tdata[7:0] == 8'h00 && !m_tdata[9],
        "drop with other fields set")

endmodule

bind i2c_target_stream_fifo_crc i2cts_checker u_i2cts_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for i2c_target_stream_fifo_crc: drives bus and local events,
// predicts every result transfer and compares it field by field.
// Depends on i2cts_pkg and the i2c_target_stream_fifo_crc RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cts_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RESERVED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0] pad;
        logic       dropped;
        logic       accepted;
        logic       nack;
        logic [7:0] read_byte;
    } result_t;

    class ring_bridge_scoreboard;
        logic [SLOT_W-1:0] slot;
        logic              first_seen;
        logic [7:0]        sel_reg;
        logic [7:0]        last_ctrl;
        logic [7:0]        in_store [RING_DEPTH];
        logic [7:0]        out_store [RING_DEPTH];
        ptr_t              in_head, in_tail, in_mark;
        ptr_t              out_head, out_tail, out_mark;
        logic [31:0]       in_crc, out_crc;
        result_t           pending_results [$];
        int                mismatches;

        function new();
            slot = '0;
            first_seen = 1'b0;
            sel_reg = '0;
            last_ctrl = '0;
            in_head = '0;
            in_tail = '0;
            in_mark = '0;
            out_head = '0;
            out_tail = '0;
            out_mark = '0;
            in_crc = CRC_PRESET;
            out_crc = CRC_PRESET;
            mismatches = 0;
            foreach (out_store[i]) out_store[i] = '0;
            foreach (in_store[i]) in_store[i] = '0;
        endfunction

        function logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'h0, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function result_t predict_event(logic [ACT_W-1:0] act, logic [7:0] data);
            result_t    r;
            logic       ours;
            logic [3:0] reg_lo;
            ptr_t       t;
            r = '0;
            case (act)
                ACT_WR_START, ACT_STOP: begin
                    first_seen = 1'b0;
                end
                ACT_WR_BYTE: begin
                    if (!first_seen) sel_reg = data;
                    ours = (sel_reg[7:4] == slot);
                    reg_lo = sel_reg[3:0];
                    if (!ours) begin
                        r.nack = 1'b1;
                    end else if (first_seen) begin
                        if (reg_lo == REG_DATA) begin
                            if (ptr_t'(in_head + 1) != in_tail) begin
                                in_store[in_head] = data;
                                in_crc = crc_fold(in_crc, data);
                                in_head = ptr_t'(in_head + 1);
                            end else begin
                                r.dropped = 1'b1;
                            end
                        end else if (reg_lo == REG_CTRL) begin
                            last_ctrl = data;
                            case (data)
                                CTRL_OUT_COMMIT: begin
                                    out_crc = CRC_PRESET;
                                    out_mark = out_tail;
                                end
                                CTRL_OUT_REWIND: begin
                                    out_crc = CRC_PRESET;
                                    out_tail = out_mark;
                                end
                                CTRL_IN_COMMIT: begin
                                    in_crc = CRC_PRESET;
                                    in_mark = in_head;
                                end
                                CTRL_IN_REWIND: begin
                                    in_crc = CRC_PRESET;
                                    in_head = in_mark;
                                end
                                default: ;
                            endcase
                        end else begin
                            r.nack = 1'b1;
                        end
                    end
                    first_seen = 1'b1;
                end
                ACT_RD_DONE: begin
                    first_seen = 1'b1;
                    if (sel_reg[3:0] != REG_DATA) begin
                        r.read_byte = 8'h00;
                    end else if (sel_reg[7:4] != slot) begin
                        r.read_byte = BYTE_FOREIGN;
                    end else begin
                        t = out_tail;
                        if (out_head != out_tail) begin
                            out_crc = crc_fold(out_crc, out_store[t]);
                            out_tail = ptr_t'(out_tail + 1);
                        end
                        r.read_byte = out_store[t];
                    end
                end
                ACT_RD_REQ: begin
                    reg_lo = sel_reg[3:0];
                    if (sel_reg[7:4] != slot) begin
                        r.read_byte = BYTE_FOREIGN;
                    end else if (reg_lo == REG_COUNT) begin
                        r.read_byte = first_seen ? 8'h00 : 8'(ptr_t'(out_head - out_tail));
                    end else if (reg_lo == REG_DATA) begin
                        r.read_byte = (out_head != out_tail) ? out_store[out_tail] : 8'h00;
                    end else if (reg_lo >= REG_OCRC0 && reg_lo <= REG_OCRC3) begin
                        r.read_byte = 8'((~out_crc) >> (8 * (reg_lo - REG_OCRC0)));
                    end else if (reg_lo >= REG_ICRC0 && reg_lo <= REG_ICRC3) begin
                        r.read_byte = 8'((~in_crc) >> (8 * (reg_lo - REG_ICRC0)));
                    end else if (reg_lo == REG_CTRL) begin
                        r.read_byte = last_ctrl;
                    end
                end
                ACT_PUSH: begin
                    if (ptr_t'(out_head + 1) != out_mark) begin
                        out_store[out_head] = data;
                        out_head = ptr_t'(out_head + 1);
                        r.accepted = 1'b1;
                    end
                end
                ACT_POP: begin
                    if (in_mark != in_tail) begin
                        r.read_byte = in_store[in_tail];
                        in_tail = ptr_t'(in_tail + 1);
                        r.accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_event(logic [ACT_W-1:0] act, logic [7:0] data);
            pending_results.push_back(predict_event(act, data));
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result transfer with nothing pending: %h", got);
                return;
            end
            exp = pending_results.pop_front();
            if (got.read_byte != exp.read_byte || got.nack != exp.nack
                || got.accepted != exp.accepted || got.dropped != exp.dropped
                || got.pad != exp.pad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: read_byte %h/%h nack %b/%b accepted %b/%b dropped %b/%b pad %h/%h (exp/got)",
                             exp.read_byte, got.read_byte, exp.nack, got.nack,
                             exp.accepted, got.accepted, exp.dropped, got.dropped,
                             exp.pad, got.pad);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [SLOT_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;

    ring_bridge_scoreboard scoreboard;
    logic [SLOT_W-1:0]     cur_slot;
    bit                    send_quiet;
    bit                    recv_quiet;
    int                    events_sent;
    int                    quiet_cycles;

    always #5 aclk = ~aclk;

    i2c_target_stream_fifo_crc u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) scoreboard.note_event(s_tuser, s_tdata);
            if (m_tvalid && m_tready) scoreboard.check_result(result_t'(m_tdata));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result sink with random back-pressure
    initial begin
        int gap;
        m_tready <= 1'b0;
        recv_quiet = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic issue_event(input logic [ACT_W-1:0] act, input logic [7:0] data);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (scoreboard.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_slot(input logic [SLOT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scoreboard.slot = v;
        cur_slot = v;
    endtask

    function automatic logic [3:0] pick_nibble();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom) : cur_slot;
    endfunction

    function automatic logic [7:0] pick_ctrl();
        case ($urandom_range(0, 4))
            0: return CTRL_OUT_COMMIT;
            1: return CTRL_OUT_REWIND;
            2: return CTRL_IN_COMMIT;
            3: return CTRL_IN_REWIND;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_sequence();
        int k, n;
        logic [3:0] reg_lo;
        if ($urandom_range(0, 7) == 0) send_quiet = ~send_quiet;
        k = $urandom_range(0, 19);
        if (k < 6) begin
            issue_event(ACT_WR_START, 8'($urandom));
            issue_event(ACT_WR_BYTE, {pick_nibble(), REG_DATA});
            n = $urandom_range(1, 8);
            repeat (n) issue_event(ACT_WR_BYTE, 8'($urandom));
            issue_event(ACT_STOP, 8'($urandom));
        end else if (k < 9) begin
            issue_event(ACT_WR_START, 8'($urandom));
            issue_event(ACT_WR_BYTE, {pick_nibble(), REG_CTRL});
            n = $urandom_range(1, 2);
            repeat (n) issue_event(ACT_WR_BYTE, pick_ctrl());
            issue_event(ACT_STOP, 8'($urandom));
        end else if (k < 13) begin
            reg_lo = $urandom_range(0, 1) ? 4'($urandom_range(0, 1)) : 4'($urandom);
            issue_event(ACT_WR_START, 8'($urandom));
            issue_event(ACT_WR_BYTE, {pick_nibble(), reg_lo});
            if ($urandom_range(0, 1)) issue_event(ACT_STOP, 8'($urandom));
            n = $urandom_range(1, 6);
            repeat (n) begin
                issue_event(ACT_RD_REQ, 8'($urandom));
                if ($urandom_range(0, 5) != 0) issue_event(ACT_RD_DONE, 8'($urandom));
            end
            issue_event(ACT_STOP, 8'($urandom));
        end else if (k < 16) begin
            n = $urandom_range(1, 10);
            repeat (n) issue_event(ACT_PUSH, 8'($urandom));
        end else if (k < 19) begin
            n = $urandom_range(1, 10);
            repeat (n) issue_event(ACT_POP, 8'($urandom));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) issue_event(3'($urandom_range(0, 7)), 8'($urandom));
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = events_sent;
        while (events_sent - start < n) random_sequence();
    endtask

    initial begin
        scoreboard  = new();
        cur_slot    = '0;
        send_quiet  = 1'b0;
        events_sent = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_WR_START;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_slot(4'h0);

        // empty-ring reads, count visibility, commits, rewinds, foreign and unused registers
        issue_event(ACT_RD_REQ, 8'h00);
        issue_event(ACT_RD_DONE, 8'h00);
        issue_event(ACT_PUSH, 8'h00);
        issue_event(ACT_PUSH, 8'hFF);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, {cur_slot, REG_COUNT});
        issue_event(ACT_STOP, 8'h00);
        issue_event(ACT_RD_REQ, 8'h00);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, {cur_slot, REG_DATA});
        issue_event(ACT_RD_DONE, 8'h00);
        issue_event(ACT_WR_BYTE, 8'hFF);
        issue_event(ACT_WR_BYTE, 8'h00);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, {cur_slot, REG_CTRL});
        issue_event(ACT_WR_BYTE, CTRL_IN_COMMIT);
        issue_event(ACT_WR_BYTE, CTRL_OUT_COMMIT);
        issue_event(ACT_RD_REQ, 8'h00);
        issue_event(ACT_POP, 8'h00);
        issue_event(ACT_WR_BYTE, CTRL_IN_REWIND);
        issue_event(ACT_WR_BYTE, CTRL_OUT_REWIND);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, {cur_slot, REG_ICRC0});
        issue_event(ACT_RD_REQ, 8'h00);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, 8'hF3);
        issue_event(ACT_RD_REQ, 8'h00);
        issue_event(ACT_WR_START, 8'h00);
        issue_event(ACT_WR_BYTE, {cur_slot, 4'hB});
        issue_event(ACT_WR_BYTE, 8'h12);
        issue_event(ACT_RESERVED, 8'hFF);

        run_random(100);
        drain_results();
        write_slot(4'hF);

        // overfill both rings
        issue_event(ACT_WR_START, 8'($urandom));
        issue_event(ACT_WR_BYTE, {cur_slot, REG_DATA});
        repeat (RING_DEPTH) issue_event(ACT_WR_BYTE, 8'($urandom));
        issue_event(ACT_STOP, 8'($urandom));
        repeat (RING_DEPTH) issue_event(ACT_PUSH, 8'($urandom));
        issue_event(ACT_WR_START, 8'($urandom));
        issue_event(ACT_WR_BYTE, {cur_slot, REG_COUNT});
        issue_event(ACT_STOP, 8'($urandom));
        issue_event(ACT_RD_REQ, 8'($urandom));
        run_random(60);
        drain_results();
        write_slot(4'($urandom_range(1, 14)));
        run_random(100);
        drain_results();
        write_slot(4'h0);
        run_random(60);
        drain_results();
        repeat (10) @(posedge aclk);

        if (scoreboard.mismatches == 0 && scoreboard.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- i2c_target_stream_fifo_crc.f -----
+incdir+rtl
rtl/i2cts_pkg.sv
rtl/i2cts_ram.sv
rtl/i2c_target_stream_fifo_crc.sv
rtl/i2cts_checker.sv
sim/testbench.sv
